>>> rtl/pat_pkg.sv
`default_nettype none

package pat_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMPW  = (CW > 5) ? CW : 5;
	localparam int DW    = 32;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_REPLACE = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_DUMP    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_BAD      = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_INS_RD,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_WR,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_INC,
		PTR_DEC,
		PTR_LOAD
	} ptr_op_t;

	typedef enum logic [1:0] {
		PSRC_ZERO,
		PSRC_POS,
		PSRC_COUNT
	} ptr_src_t;

	typedef enum logic [1:0] {
		RA_PTR,
		RA_PREV,
		RA_NEXT
	} rd_addr_t;

	// WA_PTR writes the read data back at ptr, WA_POS writes the held value at pos
	typedef enum logic {
		WA_PTR,
		WA_POS
	} wr_addr_t;

	typedef struct packed {
		logic     load;
		ptr_op_t  ptr_op;
		ptr_src_t ptr_src;
		logic     re;
		rd_addr_t rd_addr;
		logic     we;
		wr_addr_t wr_addr;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     emit;
		logic     emit_data;
		logic     emit_idx;
		logic     emit_last;
		status_t  status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
		logic ptr_gt_pos;
		logic next_lt_cnt;
		logic ptr_lt_cnt;
		logic ptr_last;
		logic match;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/pat_if.sv
`default_nettype none

interface pat_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  operation;
	logic        [4:0]  position;
	logic signed [31:0] value;

	modport source (output valid, operation, position, value, input ready);
	modport sink   (input valid, operation, position, value, output ready);
endinterface

interface pat_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] data;
	logic        [3:0]  found_index;
	logic        [4:0]  fill_count;
	logic               last;

	modport source (output valid, status, data, found_index, fill_count, last, input ready);
	modport sink   (input valid, status, data, found_index, fill_count, last, output ready);
endinterface

`default_nettype wire

>>> rtl/pat_ram.sv
`default_nettype none

module pat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pat_dp.sv
`default_nettype none

module pat_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pat_pkg::cmd_t      cmd,
	output      pat_pkg::stat_t     st,
	input  wire logic        [2:0]  req_operation,
	input  wire logic        [4:0]  req_position,
	input  wire logic signed [31:0] req_value,
	output      logic               rsp_valid,
	input  wire logic               rsp_ready,
	output      logic        [1:0]  rsp_status,
	output      logic signed [31:0] rsp_data,
	output      logic        [3:0]  rsp_found_index,
	output      logic        [4:0]  rsp_fill_count,
	output      logic               rsp_last
);

	pat_pkg::op_t                op_q;
	logic [4:0]                  pos_q;
	logic [pat_pkg::DW-1:0]      val_q;
	logic [pat_pkg::CW-1:0]      cnt_q;
	logic [pat_pkg::CW-1:0]      ptr_q;
	logic [pat_pkg::CMPW-1:0]    cnt_x, pos_x, ptr_x;
	logic [pat_pkg::CMPW:0]      ptr_nx;
	logic [pat_pkg::CW-1:0]      ptr_prev, ptr_next, ptr_ld;
	logic [pat_pkg::AW-1:0]      raddr, waddr;
	logic [pat_pkg::DW-1:0]      wdata, rdata;

	logic                        valid_q;
	logic [1:0]                  status_q;
	logic [pat_pkg::DW-1:0]      data_q;
	logic [3:0]                  idx_q;
	logic [4:0]                  fill_q;
	logic                        last_q;

	assign cnt_x    = pat_pkg::CMPW'(cnt_q);
	assign pos_x    = pat_pkg::CMPW'(pos_q);
	assign ptr_x    = pat_pkg::CMPW'(ptr_q);
	assign ptr_nx   = {1'b0, ptr_x} + (pat_pkg::CMPW + 1)'(1);
	assign ptr_prev = ptr_q - pat_pkg::CW'(1);
	assign ptr_next = ptr_q + pat_pkg::CW'(1);

	always_comb begin
		st             = '0;
		st.op          = op_q;
		st.empty       = (cnt_q == '0);
		st.full        = (cnt_x == pat_pkg::CMPW'(pat_pkg::DEPTH));
		st.pos_gt_cnt  = (pos_x > cnt_x);
		st.pos_ge_cnt  = (pos_x >= cnt_x);
		st.ptr_gt_pos  = (ptr_x > pos_x);
		st.next_lt_cnt = (ptr_nx < {1'b0, cnt_x});
		st.ptr_lt_cnt  = (ptr_x < cnt_x);
		st.ptr_last    = (ptr_nx == {1'b0, cnt_x});
		st.match       = (rdata == val_q);
		st.out_free    = !valid_q || rsp_ready;
	end

	always_comb begin
		case (cmd.ptr_src)
			pat_pkg::PSRC_POS:   ptr_ld = pat_pkg::CW'(pos_q);
			pat_pkg::PSRC_COUNT: ptr_ld = cnt_q;
			default:             ptr_ld = '0;
		endcase
	end

	always_comb begin
		case (cmd.rd_addr)
			pat_pkg::RA_PREV: raddr = ptr_prev[pat_pkg::AW-1:0];
			pat_pkg::RA_NEXT: raddr = ptr_next[pat_pkg::AW-1:0];
			default:          raddr = ptr_q[pat_pkg::AW-1:0];
		endcase
	end

	assign waddr = (cmd.wr_addr == pat_pkg::WA_POS) ? pat_pkg::AW'(pos_q) : ptr_q[pat_pkg::AW-1:0];
	assign wdata = (cmd.wr_addr == pat_pkg::WA_POS) ? val_q : rdata;

	pat_ram #(
		.WIDTH (pat_pkg::DW),
		.DEPTH (pat_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= pat_pkg::op_t'(req_operation);
			pos_q <= req_position;
			val_q <= req_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + pat_pkg::CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - pat_pkg::CW'(1);
			end
			case (cmd.ptr_op)
				pat_pkg::PTR_INC:  ptr_q <= ptr_next;
				pat_pkg::PTR_DEC:  ptr_q <= ptr_prev;
				pat_pkg::PTR_LOAD: ptr_q <= ptr_ld;
				default:           ptr_q <= ptr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.status;
			data_q   <= cmd.emit_data ? rdata : '0;
			idx_q    <= cmd.emit_idx ? ptr_x[3:0] : 4'd0;
			fill_q   <= cnt_x[4:0];
			last_q   <= cmd.emit_last;
		end
	end

	assign rsp_valid       = valid_q;
	assign rsp_status      = status_q;
	assign rsp_data        = data_q;
	assign rsp_found_index = idx_q;
	assign rsp_fill_count  = fill_q;
	assign rsp_last        = last_q;

endmodule

`default_nettype wire

>>> rtl/pat_ctrl.sv
`default_nettype none

module pat_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output      logic           req_ready,
	input  wire pat_pkg::stat_t st,
	output      pat_pkg::cmd_t  cmd
);

	pat_pkg::state_t  state_q, state_d;
	pat_pkg::status_t resp_q, resp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pat_pkg::S_IDLE;
			resp_q  <= pat_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		resp_d    = resp_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			pat_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = pat_pkg::S_DECIDE;
				end
			end
			pat_pkg::S_DECIDE: begin
				state_d = pat_pkg::S_RESP;
				case (st.op)
					pat_pkg::OP_INSERT: begin
						if (st.full || st.pos_gt_cnt) begin
							resp_d = pat_pkg::ST_BAD;
						end else begin
							cmd.ptr_op  = pat_pkg::PTR_LOAD;
							cmd.ptr_src = pat_pkg::PSRC_COUNT;
							state_d     = pat_pkg::S_INS_RD;
						end
					end
					pat_pkg::OP_DELETE: begin
						if (st.empty) begin
							resp_d = pat_pkg::ST_EMPTY;
						end else if (st.pos_ge_cnt) begin
							resp_d = pat_pkg::ST_BAD;
						end else begin
							cmd.ptr_op  = pat_pkg::PTR_LOAD;
							cmd.ptr_src = pat_pkg::PSRC_POS;
							state_d     = pat_pkg::S_DEL_RD;
						end
					end
					pat_pkg::OP_REPLACE: begin
						if (st.empty) begin
							resp_d = pat_pkg::ST_EMPTY;
						end else if (st.pos_ge_cnt) begin
							resp_d = pat_pkg::ST_BAD;
						end else begin
							cmd.we      = 1'b1;
							cmd.wr_addr = pat_pkg::WA_POS;
							resp_d      = pat_pkg::ST_OK;
						end
					end
					pat_pkg::OP_SEARCH: begin
						if (st.empty) begin
							resp_d = pat_pkg::ST_EMPTY;
						end else begin
							cmd.ptr_op  = pat_pkg::PTR_LOAD;
							cmd.ptr_src = pat_pkg::PSRC_ZERO;
							state_d     = pat_pkg::S_SRCH_RD;
						end
					end
					pat_pkg::OP_DUMP: begin
						if (st.empty) begin
							resp_d = pat_pkg::ST_EMPTY;
						end else begin
							cmd.ptr_op  = pat_pkg::PTR_LOAD;
							cmd.ptr_src = pat_pkg::PSRC_ZERO;
							state_d     = pat_pkg::S_DUMP_RD;
						end
					end
					default: begin
						resp_d = pat_pkg::ST_BAD;
					end
				endcase
			end
			pat_pkg::S_INS_RD: begin
				if (st.ptr_gt_pos) begin
					cmd.re      = 1'b1;
					cmd.rd_addr = pat_pkg::RA_PREV;
					state_d     = pat_pkg::S_INS_WR;
				end else begin
					cmd.we      = 1'b1;
					cmd.wr_addr = pat_pkg::WA_POS;
					cmd.cnt_inc = 1'b1;
					resp_d      = pat_pkg::ST_OK;
					state_d     = pat_pkg::S_RESP;
				end
			end
			pat_pkg::S_INS_WR: begin
				cmd.we      = 1'b1;
				cmd.wr_addr = pat_pkg::WA_PTR;
				cmd.ptr_op  = pat_pkg::PTR_DEC;
				state_d     = pat_pkg::S_INS_RD;
			end
			pat_pkg::S_DEL_RD: begin
				if (st.next_lt_cnt) begin
					cmd.re      = 1'b1;
					cmd.rd_addr = pat_pkg::RA_NEXT;
					state_d     = pat_pkg::S_DEL_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					resp_d      = pat_pkg::ST_OK;
					state_d     = pat_pkg::S_RESP;
				end
			end
			pat_pkg::S_DEL_WR: begin
				cmd.we      = 1'b1;
				cmd.wr_addr = pat_pkg::WA_PTR;
				cmd.ptr_op  = pat_pkg::PTR_INC;
				state_d     = pat_pkg::S_DEL_RD;
			end
			pat_pkg::S_SRCH_RD: begin
				if (st.ptr_lt_cnt) begin
					cmd.re      = 1'b1;
					cmd.rd_addr = pat_pkg::RA_PTR;
					state_d     = pat_pkg::S_SRCH_CHK;
				end else begin
					resp_d  = pat_pkg::ST_NOTFOUND;
					state_d = pat_pkg::S_RESP;
				end
			end
			pat_pkg::S_SRCH_CHK: begin
				if (st.match) begin
					resp_d  = pat_pkg::ST_OK;
					state_d = pat_pkg::S_RESP;
				end else begin
					cmd.ptr_op = pat_pkg::PTR_INC;
					state_d    = pat_pkg::S_SRCH_RD;
				end
			end
			pat_pkg::S_DUMP_RD: begin
				cmd.re      = 1'b1;
				cmd.rd_addr = pat_pkg::RA_PTR;
				state_d     = pat_pkg::S_DUMP_OUT;
			end
			pat_pkg::S_DUMP_OUT: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_data = 1'b1;
					cmd.emit_last = st.ptr_last;
					cmd.status    = pat_pkg::ST_OK;
					if (st.ptr_last) begin
						state_d = pat_pkg::S_IDLE;
					end else begin
						cmd.ptr_op = pat_pkg::PTR_INC;
						state_d    = pat_pkg::S_DUMP_RD;
					end
				end
			end
			pat_pkg::S_RESP: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.status    = resp_q;
					cmd.emit_idx  = (st.op == pat_pkg::OP_SEARCH) && (resp_q == pat_pkg::ST_OK);
					state_d       = pat_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pat_pkg::S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result emitted over a waiting beat");
	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !st.full)
		else $error("fill count raised on a full table");
	a_dec_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !st.empty)
		else $error("fill count lowered on an empty table");
	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.re && cmd.we && (cmd.wr_addr == pat_pkg::WA_POS)))
		else $error("read and final write in the same cycle");
	a_load_decide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == pat_pkg::S_DECIDE))
		else $error("accepted beat not decoded next cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/positional_array_table.sv
// Ordered table of up to 16 signed 32-bit entries with a fill count.
// req channel: one beat per operation (insert, delete, replace, search, dump),
// taken only while the controller is idle, so one operation runs at a time.
// rsp channel: one beat per operation, or one beat per stored entry for a
// non-empty dump, the final beat of each operation with last set.
// Replace and every rejected or empty-table operation go from decode to the
// result; insert moves the entries from position up one place, last first,
// then writes the value; delete moves the entries above position down one
// place; search reads from entry 0 until a hit or the fill count; dump reads
// each entry into a result beat, waiting while rsp stalls. The controller is
// back in idle for the next req beat in the cycle after the final result is
// loaded. The walks use a table memory with separate read and write ports
// and registered read, one read and one write per moved entry.
// The result sits in an output register; a stall on rsp holds it and the
// controller waits before loading the next result beat.
// Reset clears the fill count and the control state; table contents are
// not cleared and are only read below the fill count.
`default_nettype none

module positional_array_table (
	input wire logic clk,
	input wire logic arst_n,
	pat_req_if.sink  req,
	pat_rsp_if.source rsp
);

	pat_pkg::cmd_t  cmd;
	pat_pkg::stat_t st;

	pat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	pat_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.req_operation   (req.operation),
		.req_position    (req.position),
		.req_value       (req.value),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_status      (rsp.status),
		.rsp_data        (rsp.data),
		.rsp_found_index (rsp.found_index),
		.rsp_fill_count  (rsp.fill_count),
		.rsp_last        (rsp.last)
	);

endmodule

`default_nettype wire

>>> verif/pat_table_checker.sv
`timescale 1ns / 100ps

module pat_table_checker
	import pat_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	input  wire logic                 req_ready,
	input  wire logic [2:0]           req_operation,
	input  wire logic [4:0]           req_position,
	input  wire logic signed [DW-1:0] req_value,
	input  wire logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	input  wire logic [1:0]           rsp_status,
	input  wire logic signed [DW-1:0] rsp_data,
	input  wire logic [3:0]           rsp_found_index,
	input  wire logic [4:0]           rsp_fill_count,
	input  wire logic                 rsp_last,
	output int                        errors,
	output int                        pending,
	output logic [CW-1:0]             table_fill
);

	typedef struct packed {
		status_t              status;
		logic signed [DW-1:0] data;
		logic [3:0]           found_index;
		logic [4:0]           fill_count;
		logic                 last;
	} table_beat_t;

	logic signed [DW-1:0] entries [DEPTH];
	logic [CW-1:0]        fill = '0;
	table_beat_t          owed_beats [$];
	table_beat_t          want;
	int                   fail_count = 0;
	int                   owed_n = 0;

	assign errors     = fail_count;
	assign pending    = owed_n;
	assign table_fill = fill;

	task automatic owe_beat(input status_t st, input logic signed [DW-1:0] d,
			input logic [3:0] idx, input logic lst);
		owed_beats.push_back('{status: st, data: d, found_index: idx,
			fill_count: fill, last: lst});
	endtask

	task automatic apply_table_op(input logic [2:0] op, input logic [4:0] pos,
			input logic signed [DW-1:0] val);
		logic       hit;
		logic [3:0] hit_idx;
		int         i;
		hit = 1'b0;
		hit_idx = '0;
		case (op)
		OP_INSERT: begin
			if (fill >= DEPTH || pos > fill) begin
				owe_beat(ST_BAD, '0, '0, 1'b1);
			end else begin
				for (i = fill; i > pos; i--)
					entries[i] = entries[i - 1];
				entries[pos] = val;
				fill++;
				owe_beat(ST_OK, '0, '0, 1'b1);
			end
		end
		OP_DELETE: begin
			if (fill == 0) begin
				owe_beat(ST_EMPTY, '0, '0, 1'b1);
			end else if (pos >= fill) begin
				owe_beat(ST_BAD, '0, '0, 1'b1);
			end else begin
				for (i = pos; i + 1 < fill; i++)
					entries[i] = entries[i + 1];
				fill--;
				owe_beat(ST_OK, '0, '0, 1'b1);
			end
		end
		OP_REPLACE: begin
			if (fill == 0) begin
				owe_beat(ST_EMPTY, '0, '0, 1'b1);
			end else if (pos >= fill) begin
				owe_beat(ST_BAD, '0, '0, 1'b1);
			end else begin
				entries[pos] = val;
				owe_beat(ST_OK, '0, '0, 1'b1);
			end
		end
		OP_SEARCH: begin
			if (fill == 0) begin
				owe_beat(ST_EMPTY, '0, '0, 1'b1);
			end else begin
				for (i = 0; i < fill; i++) begin
					if (!hit && entries[i] == val) begin
						hit = 1'b1;
						hit_idx = i[3:0];
					end
				end
				if (hit)
					owe_beat(ST_OK, '0, hit_idx, 1'b1);
				else
					owe_beat(ST_NOTFOUND, '0, '0, 1'b1);
			end
		end
		OP_DUMP: begin
			if (fill == 0) begin
				owe_beat(ST_EMPTY, '0, '0, 1'b1);
			end else begin
				for (i = 0; i < fill; i++)
					owe_beat(ST_OK, entries[i], '0, i == fill - 1);
			end
		end
		default: owe_beat(ST_BAD, '0, '0, 1'b1);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = '0;
			owed_beats.delete();
			owed_n = 0;
		end else begin
			if (req_valid && req_ready)
				apply_table_op(req_operation, req_position, req_value);
			if (rsp_valid && rsp_ready) begin
				if (owed_beats.size() == 0) begin
					$error("result beat with no expectation pending");
					fail_count++;
				end else begin
					want = owed_beats.pop_front();
					if (rsp_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_status);
						fail_count++;
					end
					if (rsp_data !== want.data) begin
						$error("data: expected %0d, got %0d", want.data, rsp_data);
						fail_count++;
					end
					if (rsp_found_index !== want.found_index) begin
						$error("found_index: expected %0d, got %0d",
							want.found_index, rsp_found_index);
						fail_count++;
					end
					if (rsp_fill_count !== want.fill_count) begin
						$error("fill_count: expected %0d, got %0d",
							want.fill_count, rsp_fill_count);
						fail_count++;
					end
					if (rsp_last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp_last);
						fail_count++;
					end
				end
			end
			owed_n = owed_beats.size();
		end
	end

endmodule

>>> verif/tb_positional_array_table.sv
`timescale 1ns / 100ps

module tb_positional_array_table;
	import pat_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 85;
	localparam int HOLD_CYCLES  = 400;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pat_req_if req();
	pat_rsp_if rsp();

	positional_array_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	int            chk_errors;
	int            chk_pending;
	logic [CW-1:0] chk_fill;

	pat_table_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req.valid),
		.req_ready       (req.ready),
		.req_operation   (req.operation),
		.req_position    (req.position),
		.req_value       (req.value),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_status      (rsp.status),
		.rsp_data        (rsp.data),
		.rsp_found_index (rsp.found_index),
		.rsp_fill_count  (rsp.fill_count),
		.rsp_last        (rsp.last),
		.errors          (chk_errors),
		.pending         (chk_pending),
		.table_fill      (chk_fill)
	);

	int   send_gap_pct   = 0;
	int   recv_stall_pct = 0;
	bit   hold_req       = 1'b0;
	bit   growing        = 1'b1;
	logic req_took       = 1'b0;
	int   cycles         = 0;

	int gap_by_phase   [4] = '{0, 49, 0, 10};
	int stall_by_phase [4] = '{0, 0, 49, 10};

	always #10 clk = ~clk;

	always @(posedge clk) begin
		req_took <= req.valid && req.ready;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_op(input logic [2:0] op, input logic [4:0] pos,
			input logic [31:0] val);
		while ($urandom_range(99) < send_gap_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.position  <= pos;
		req.value     <= val;
		do @(negedge clk); while (!req_took);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
		0, 1, 2, 3, 4: return 32'($urandom_range(7));
		5: begin
			case ($urandom_range(3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			default: return 32'h0;
			endcase
		end
		default: return $urandom;
		endcase
	endfunction

	task automatic send_random_op();
		int n;
		int r;
		n = chk_fill;
		if (n >= DEPTH)
			growing = 1'b0;
		else if (n == 0)
			growing = 1'b1;
		r = $urandom_range(99);
		if (r < 7) begin
			if ($urandom_range(1))
				send_op(3'($urandom_range(5, 7)), 5'($urandom_range(31)), $urandom);
			else
				send_op(3'($urandom_range(OP_INSERT, OP_REPLACE)),
					5'($urandom_range(31)), pick_value());
		end else if (r < (growing ? 47 : 22)) begin
			send_op(OP_INSERT, 5'($urandom_range(n)), pick_value());
		end else if (r < 59) begin
			send_op(OP_DELETE, (n > 0) ? 5'($urandom_range(n - 1)) : 5'd0, $urandom);
		end else if (r < 74) begin
			send_op(OP_REPLACE, (n > 0) ? 5'($urandom_range(n - 1)) : 5'd0,
				pick_value());
		end else if (r < 89) begin
			send_op(OP_SEARCH, 5'($urandom_range(31)), pick_value());
		end else begin
			send_op(OP_DUMP, 5'($urandom_range(31)), $urandom);
		end
	endtask

	// fill to capacity with random content, overflow once, dump the lot
	task automatic fill_and_dump();
		while (chk_fill < DEPTH)
			send_op(OP_INSERT, 5'($urandom_range(chk_fill)), pick_value());
		send_op(OP_INSERT, 5'(chk_fill), $urandom);
		send_op(OP_DUMP, 5'd0, 32'h0);
	endtask

	initial begin
		int wait_cnt;
		req.valid     = 1'b0;
		req.operation = OP_INSERT;
		req.position  = '0;
		req.value     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_op(OP_DUMP,    5'd0,  32'h0);
		send_op(OP_SEARCH,  5'd0,  32'h0);
		send_op(OP_DELETE,  5'd0,  32'h0);
		send_op(OP_REPLACE, 5'd0,  32'h1);
		send_op(OP_INSERT,  5'd1,  32'h1);
		send_op(OP_INSERT,  5'd0,  32'h7fff_ffff);
		send_op(OP_INSERT,  5'd1,  32'h8000_0000);
		send_op(OP_INSERT,  5'd0,  32'hffff_ffff);
		send_op(OP_INSERT,  5'd2,  32'h0);
		send_op(OP_SEARCH,  5'd31, 32'h8000_0000);
		send_op(OP_SEARCH,  5'd0,  32'd12345);
		send_op(OP_SEARCH,  5'd0,  32'hffff_ffff);
		send_op(OP_REPLACE, 5'd4,  32'h1);
		send_op(OP_REPLACE, 5'd3,  32'h5555_5555);
		send_op(OP_DELETE,  5'd31, 32'h0);
		send_op(OP_DELETE,  5'd4,  32'h0);
		send_op(OP_DELETE,  5'd1,  32'hffff_ffff);
		send_op(OP_INSERT,  5'd4,  32'h2);
		send_op(3'd5,       5'd31, 32'hffff_ffff);
		send_op(3'd6,       5'd16, 32'h8000_0000);
		send_op(3'd7,       5'd0,  32'h7fff_ffff);
		send_op(OP_DUMP,    5'd31, 32'hffff_ffff);
		send_op(OP_INSERT,  5'd3,  32'haaaa_aaaa);

		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct   = gap_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			fill_and_dump();
			if (ph == 0)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) send_random_op();
		end
		req.valid <= 1'b0;

		wait_cnt = 0;
		while (chk_pending != 0 && wait_cnt < 50000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (100) @(negedge clk);
		if (chk_errors == 0 && chk_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
